### hdl/rks_pkg.sv
// ----------------------------------------------------------------------------
// rks_pkg
// Shared types and constants for the radar keypoint selector.
// ----------------------------------------------------------------------------
package rks_pkg;

  // Range bounds are fixed at 16 bits, their squares at 32 bits
  localparam int unsigned RANGE_W    = 16;
  localparam int unsigned RANGE_SQ_W = 2 * RANGE_W;

  // Configuration register index width
  localparam int unsigned CFG_IDX_W = 3;

  // Reset values of the range window, held as squares
  localparam logic [RANGE_SQ_W-1:0] RANGE_LO_SQ_RST = '0;
  localparam logic [RANGE_SQ_W-1:0] RANGE_HI_SQ_RST = 32'd2147488281; // 46341 squared

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RCS_LOW       = 3'd0,
    CFG_RCS_HIGH      = 3'd1,
    CFG_RANGE_LOW     = 3'd2,
    CFG_RANGE_HIGH    = 3'd3,
    CFG_KEY_IS_RANGE  = 3'd4,
    CFG_PICK_SMALLEST = 3'd5
  } cfg_reg_e;

  // Range window and key selection handed to the qualifier
  typedef struct packed {
    logic [RANGE_SQ_W-1:0] range_lo_sq;
    logic [RANGE_SQ_W-1:0] range_hi_sq;
    logic                  key_is_range;
  } rng_cfg_t;

endpackage

### hdl/rks_det_if.sv
// ----------------------------------------------------------------------------
// rks_det_if
// Detection channel: one radar detection per transfer.
// ----------------------------------------------------------------------------
interface rks_det_if #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned RCS_WIDTH   = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  logic signed [RCS_WIDTH-1:0]   cross_section;
  logic                          last_point;

  modport source (
    output valid, pos_x, pos_y, pos_z, cross_section, last_point,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, cross_section, last_point,
    output ready
  );
endinterface

### hdl/rks_res_if.sv
// ----------------------------------------------------------------------------
// rks_res_if
// Result channel: the selected keypoint of one cloud per transfer.
// ----------------------------------------------------------------------------
interface rks_res_if #(
  parameter int unsigned COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic signed [COORD_WIDTH-1:0] best_x;
  logic signed [COORD_WIDTH-1:0] best_y;
  logic signed [COORD_WIDTH-1:0] best_z;

  modport source (
    output valid, found, best_x, best_y, best_z,
    input  ready
  );
  modport sink (
    input  valid, found, best_x, best_y, best_z,
    output ready
  );
endinterface

### hdl/rks_cfg_if.sv
// ----------------------------------------------------------------------------
// rks_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rks_cfg_if #(
  parameter int unsigned DATA_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic [rks_pkg::CFG_IDX_W-1:0]  index;
  logic [DATA_WIDTH-1:0]          data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

### hdl/rks_qualify.sv
// ----------------------------------------------------------------------------
// rks_qualify
// Window test and ranking key for one detection: squared planar range,
// RCS and range window checks, key selection.
// ----------------------------------------------------------------------------
module rks_qualify #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned RCS_WIDTH   = 16,
  parameter int unsigned KEY_W       = 33
) (
  input  logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  logic signed [RCS_WIDTH-1:0]   rcs_i,
  input  logic signed [RCS_WIDTH-1:0]   rcs_low_i,
  input  logic signed [RCS_WIDTH-1:0]   rcs_high_i,
  input  rks_pkg::rng_cfg_t             rng_cfg_i,
  output logic                          ok_o,
  output logic signed [KEY_W-1:0]       key_o
);
  import rks_pkg::*;

  localparam int unsigned SQ_W  = 2 * COORD_WIDTH;
  localparam int unsigned CMP_W = (SQ_W > RANGE_SQ_W) ? SQ_W : RANGE_SQ_W;

  logic [COORD_WIDTH-1:0] ux, uy, ax, ay;
  logic [SQ_W-1:0]        sq_x, sq_y, rsq;
  logic                   rcs_ok, rng_ok;

  // Magnitudes; the most negative code maps onto its unsigned magnitude
  always_comb begin
    ux = pos_x_i;
    uy = pos_y_i;
    ax = ux[COORD_WIDTH-1] ? COORD_WIDTH'(~ux + COORD_WIDTH'(1)) : ux;
    ay = uy[COORD_WIDTH-1] ? COORD_WIDTH'(~uy + COORD_WIDTH'(1)) : uy;
  end

  // Squared planar range, exact in SQ_W bits
  assign sq_x = SQ_W'(ax) * SQ_W'(ax);
  assign sq_y = SQ_W'(ay) * SQ_W'(ay);
  assign rsq  = sq_x + sq_y;

  // Open windows on RCS and squared range
  assign rcs_ok = (rcs_i > rcs_low_i) && (rcs_i < rcs_high_i);
  assign rng_ok = (CMP_W'(rsq) > CMP_W'(rng_cfg_i.range_lo_sq))
               && (CMP_W'(rsq) < CMP_W'(rng_cfg_i.range_hi_sq));
  assign ok_o   = rcs_ok && rng_ok;

  // Ranking key, signed so both kinds compare on one scale
  assign key_o = rng_cfg_i.key_is_range ? KEY_W'($signed({1'b0, rsq}))
                                        : KEY_W'(rcs_i);

endmodule

### hdl/radar_keypoint_select.sv
// ----------------------------------------------------------------------------
// radar_keypoint_select
// Conditional arg-min / arg-max over a stream of radar detections.
// ----------------------------------------------------------------------------
// Detections enter on det_i at up to one per cycle. Each one is registered,
// then tested and ranked against the kept candidate in the following cycle;
// that single compare-and-update loop on the kept key sets the rate of one
// detection per cycle. The result of a cloud is loaded into the output
// register at the edge where its last detection leaves the input register,
// so it reaches res_o through the input register and the output register.
// The result sits in an output register, so later detections keep flowing
// while it waits; only a last detection that meets a result not yet taken
// holds the input until res_o is read. Configuration writes on cfg_i are
// taken in every cycle and belong between clouds.
// ----------------------------------------------------------------------------
module radar_keypoint_select #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned RCS_WIDTH   = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rks_det_if.sink   det_i,
  rks_res_if.source res_o,
  rks_cfg_if.sink   cfg_i
);
  import rks_pkg::*;

  localparam int unsigned KEY_RNG_W = 2 * COORD_WIDTH + 1;
  localparam int unsigned KEY_W     = (KEY_RNG_W > RCS_WIDTH) ? KEY_RNG_W : RCS_WIDTH;
  localparam logic signed [RCS_WIDTH-1:0] RCS_MIN = {1'b1, {(RCS_WIDTH-1){1'b0}}};
  localparam logic signed [RCS_WIDTH-1:0] RCS_MAX = {1'b0, {(RCS_WIDTH-1){1'b1}}};

  // Configuration registers
  logic signed [RCS_WIDTH-1:0] rcs_low_q, rcs_high_q;
  logic [RANGE_SQ_W-1:0]       range_lo_sq_q, range_hi_sq_q;
  logic                        key_is_range_q, pick_smallest_q;
  logic [RANGE_W-1:0]          cfg_range;
  logic [RANGE_SQ_W-1:0]       cfg_range_sq;
  rng_cfg_t                    rng_cfg;

  // Input register
  logic                          s1_valid_q, s1_valid_d;
  logic signed [COORD_WIDTH-1:0] s1_x_q, s1_y_q, s1_z_q;
  logic signed [RCS_WIDTH-1:0]   s1_rcs_q;
  logic                          s1_last_q;
  logic                          s1_advance, s1_fire, det_fire;

  // Kept candidate
  logic                          have_best_q, have_best_d;
  logic signed [KEY_W-1:0]       best_key_q, best_key_d;
  logic signed [COORD_WIDTH-1:0] kept_x_q, kept_y_q, kept_z_q;
  logic signed [COORD_WIDTH-1:0] kept_x_d, kept_y_d, kept_z_d;
  logic                          ok, better, take;
  logic signed [KEY_W-1:0]       key;

  // Output register
  logic                          out_valid_q, out_valid_d;
  logic                          found_q;
  logic signed [COORD_WIDTH-1:0] best_x_q, best_y_q, best_z_q;
  logic                          found_n;
  logic signed [COORD_WIDTH-1:0] nx, ny, nz;

  // --------------------------------------------------------------------------
  // Configuration port; range bounds are squared as they are written
  assign cfg_i.ready  = 1'b1;
  assign cfg_range    = cfg_i.data[RANGE_W-1:0];
  assign cfg_range_sq = RANGE_SQ_W'(cfg_range) * RANGE_SQ_W'(cfg_range);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcs_low_q       <= RCS_MIN;
      rcs_high_q      <= RCS_MAX;
      range_lo_sq_q   <= RANGE_LO_SQ_RST;
      range_hi_sq_q   <= RANGE_HI_SQ_RST;
      key_is_range_q  <= 1'b0;
      pick_smallest_q <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_RCS_LOW:       rcs_low_q       <= cfg_i.data[RCS_WIDTH-1:0];
        CFG_RCS_HIGH:      rcs_high_q      <= cfg_i.data[RCS_WIDTH-1:0];
        CFG_RANGE_LOW:     range_lo_sq_q   <= cfg_range_sq;
        CFG_RANGE_HIGH:    range_hi_sq_q   <= cfg_range_sq;
        CFG_KEY_IS_RANGE:  key_is_range_q  <= cfg_i.data[0];
        CFG_PICK_SMALLEST: pick_smallest_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign rng_cfg.range_lo_sq  = range_lo_sq_q;
  assign rng_cfg.range_hi_sq  = range_hi_sq_q;
  assign rng_cfg.key_is_range = key_is_range_q;

  // --------------------------------------------------------------------------
  // Handshake: a last detection moves on only if the output register is free
  assign s1_advance  = !s1_last_q || !out_valid_q || res_o.ready;
  assign s1_fire     = s1_valid_q && s1_advance;
  assign det_i.ready = !s1_valid_q || s1_advance;
  assign det_fire    = det_i.valid && det_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (det_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (det_fire) begin
      s1_x_q    <= det_i.pos_x;
      s1_y_q    <= det_i.pos_y;
      s1_z_q    <= det_i.pos_z;
      s1_rcs_q  <= det_i.cross_section;
      s1_last_q <= det_i.last_point;
    end
  end

  // --------------------------------------------------------------------------
  // Window test and key
  rks_qualify #(
    .COORD_WIDTH (COORD_WIDTH),
    .RCS_WIDTH   (RCS_WIDTH),
    .KEY_W       (KEY_W)
  ) u_qualify (
    .pos_x_i    (s1_x_q),
    .pos_y_i    (s1_y_q),
    .rcs_i      (s1_rcs_q),
    .rcs_low_i  (rcs_low_q),
    .rcs_high_i (rcs_high_q),
    .rng_cfg_i  (rng_cfg),
    .ok_o       (ok),
    .key_o      (key)
  );

  // Strict compare keeps the earlier detection on a tie
  assign better = !have_best_q || (pick_smallest_q ? (key < best_key_q) : (key > best_key_q));
  assign take   = ok && better;

  // Candidate after this detection, as seen by the result
  assign found_n = have_best_q || take;
  assign nx      = take ? s1_x_q : kept_x_q;
  assign ny      = take ? s1_y_q : kept_y_q;
  assign nz      = take ? s1_z_q : kept_z_q;

  // Candidate update, cleared once the cloud is closed
  always_comb begin
    have_best_d = have_best_q;
    best_key_d  = best_key_q;
    kept_x_d    = kept_x_q;
    kept_y_d    = kept_y_q;
    kept_z_d    = kept_z_q;
    if (s1_fire) begin
      if (s1_last_q) begin
        have_best_d = 1'b0;
        best_key_d  = '0;
        kept_x_d    = '0;
        kept_y_d    = '0;
        kept_z_d    = '0;
      end else if (take) begin
        have_best_d = 1'b1;
        best_key_d  = key;
        kept_x_d    = s1_x_q;
        kept_y_d    = s1_y_q;
        kept_z_d    = s1_z_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_best_q <= 1'b0;
      best_key_q  <= '0;
      kept_x_q    <= '0;
      kept_y_q    <= '0;
      kept_z_q    <= '0;
    end else begin
      have_best_q <= have_best_d;
      best_key_q  <= best_key_d;
      kept_x_q    <= kept_x_d;
      kept_y_q    <= kept_y_d;
      kept_z_q    <= kept_z_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire && s1_last_q) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      found_q  <= found_n;
      best_x_q <= found_n ? nx : '0;
      best_y_q <= found_n ? ny : '0;
      best_z_q <= found_n ? nz : '0;
    end
  end

  assign res_o.valid  = out_valid_q;
  assign res_o.found  = found_q;
  assign res_o.best_x = best_x_q;
  assign res_o.best_y = best_y_q;
  assign res_o.best_z = best_z_q;

  // --------------------------------------------------------------------------
  // Assertions

  // Closing a cloud leaves no candidate behind
  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_last_q) |=> !have_best_q)
    else $error("candidate survived the end of a cloud");

  // An empty result carries zero coordinates
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !found_q) |-> (best_x_q == '0 && best_y_q == '0 && best_z_q == '0))
    else $error("empty result with non-zero coordinates");

  // Input only stalls behind a last detection blocked by a pending result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !det_i.ready |-> (s1_valid_q && s1_last_q && out_valid_q && !res_o.ready))
    else $error("input stalled without a pending result");

  // A candidate only appears from a detection leaving the input register
  a_candidate_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(have_best_q) |-> $past(s1_fire && !s1_last_q))
    else $error("candidate appeared without a detection");

endmodule

### dv/rks_keypoint_checker.sv
// ----------------------------------------------------------------------------
// rks_keypoint_checker
// Watches the detection, result and configuration channels of the keypoint
// selector. It keeps its own copy of the register set and the kept candidate.
// For every last detection it queues the keypoint the block must emit, and
// compares each result transfer field by field with the oldest one queued.
// ----------------------------------------------------------------------------
module rks_keypoint_checker #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned RCS_WIDTH   = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  rks_det_if   det_i,
  rks_res_if   res_i,
  rks_cfg_if   cfg_i,
  output int   mismatches_o,
  output int   outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import rks_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;
  localparam logic [RANGE_W-1:0] RANGE_HI_RST = 16'd46341;
  localparam logic signed [RCS_WIDTH-1:0] RCS_MIN = {1'b1, {(RCS_WIDTH-1){1'b0}}};
  localparam logic signed [RCS_WIDTH-1:0] RCS_MAX = {1'b0, {(RCS_WIDTH-1){1'b1}}};

  typedef struct packed {
    logic                          found;
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
  } keypoint_t;

  // Keypoints owed by the block, oldest first
  keypoint_t keypoints_due[$];

  // Register copy
  logic signed [RCS_WIDTH-1:0] rcs_lo, rcs_hi;
  logic [RANGE_W-1:0]          rng_lo, rng_hi;
  logic                        key_rng, pick_min;

  // Kept candidate of the cloud in progress
  logic                          held;
  longint                        held_key;
  logic signed [COORD_WIDTH-1:0] held_x, held_y, held_z;

  int mis_count = 0;
  assign mismatches_o = mis_count;

  task automatic flag_mismatch(input string what, input keypoint_t want, input keypoint_t got);
    mis_count++;
    if (mis_count <= REPORT_LIMIT)
      $display("rks_check: %s at %0t: expected found=%0b x=%0d y=%0d z=%0d, got found=%0b x=%0d y=%0d z=%0d",
               what, $realtime, want.found, want.x, want.y, want.z,
               got.found, got.x, got.y, got.z);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : predict
    longint    ax, ay, rsq, key;
    logic      hit, better;
    keypoint_t got, want;
    if (!rst_ni) begin
      rcs_lo   = RCS_MIN;
      rcs_hi   = RCS_MAX;
      rng_lo   = '0;
      rng_hi   = RANGE_HI_RST;
      key_rng  = 1'b0;
      pick_min = 1'b0;
      held     = 1'b0;
      held_key = 0;
      held_x   = '0;
      held_y   = '0;
      held_z   = '0;
      keypoints_due.delete();
      outstanding_o = 0;
    end else begin
      // Result transfer: compare with the oldest keypoint owed
      if (res_i.valid && res_i.ready) begin
        got.found = res_i.found;
        got.x     = res_i.best_x;
        got.y     = res_i.best_y;
        got.z     = res_i.best_z;
        if (keypoints_due.size() == 0) begin
          want = '0;
          flag_mismatch("unexpected result", want, got);
        end else begin
          want = keypoints_due.pop_front();
          if (got.found !== want.found || got.x !== want.x ||
              got.y !== want.y || got.z !== want.z)
            flag_mismatch("wrong keypoint", want, got);
        end
      end

      // Detection transfer: qualify, rank, and close the cloud on the last one
      if (det_i.valid && det_i.ready) begin
        ax  = longint'(det_i.pos_x);
        ay  = longint'(det_i.pos_y);
        if (ax < 0) ax = -ax;
        if (ay < 0) ay = -ay;
        rsq = ax * ax + ay * ay;
        hit = det_i.cross_section > rcs_lo && det_i.cross_section < rcs_hi &&
              rsq > longint'(rng_lo) * longint'(rng_lo) &&
              rsq < longint'(rng_hi) * longint'(rng_hi);
        key = key_rng ? rsq : longint'(det_i.cross_section);
        better = !held || (pick_min ? key < held_key : key > held_key);
        if (hit && better) begin
          held     = 1'b1;
          held_key = key;
          held_x   = det_i.pos_x;
          held_y   = det_i.pos_y;
          held_z   = det_i.pos_z;
        end
        if (det_i.last_point) begin
          want.found = held;
          want.x     = held ? held_x : '0;
          want.y     = held ? held_y : '0;
          want.z     = held ? held_z : '0;
          keypoints_due.push_back(want);
          held     = 1'b0;
          held_key = 0;
          held_x   = '0;
          held_y   = '0;
          held_z   = '0;
        end
      end

      // Register write, effective from the next detection
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_reg_e'(cfg_i.index))
          CFG_RCS_LOW:       rcs_lo   = cfg_i.data[RCS_WIDTH-1:0];
          CFG_RCS_HIGH:      rcs_hi   = cfg_i.data[RCS_WIDTH-1:0];
          CFG_RANGE_LOW:     rng_lo   = cfg_i.data[RANGE_W-1:0];
          CFG_RANGE_HIGH:    rng_hi   = cfg_i.data[RANGE_W-1:0];
          CFG_KEY_IS_RANGE:  key_rng  = cfg_i.data[0];
          CFG_PICK_SMALLEST: pick_min = cfg_i.data[0];
          default: ;
        endcase
      end

      outstanding_o = keypoints_due.size();
    end
  end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the radar keypoint selector. A directed part covers field
// extremes, both keys, both directions, ties and empty windows; random
// clouds under random register settings follow. Detections come in bursts
// with random gaps, the result side stalls on its own pattern, and the
// checker beside the block decides what is correct.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rks_pkg::*;

  localparam int unsigned COORD_WIDTH   = 16;
  localparam int unsigned RCS_WIDTH     = 16;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int          RANGE_MAX     = 46341;
  localparam int          COORD_MIN     = -32768;
  localparam int          COORD_MAX     = 32767;
  localparam int unsigned DETS_TARGET   = 1400;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned QUIET_LIMIT   = 1000;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_FULL} stall_mode_e;

  logic clk_i;
  logic rst_ni = 1'b0;

  rks_det_if #(.COORD_WIDTH(COORD_WIDTH), .RCS_WIDTH(RCS_WIDTH)) det_bus ();
  rks_res_if #(.COORD_WIDTH(COORD_WIDTH))                        res_bus ();
  rks_cfg_if #(.DATA_WIDTH(CFG_DATA_W))                          cfg_bus ();

  int mismatches;
  int outstanding;
  int burst_left   = 0;
  int dets_sent    = 0;
  int quiet_cycles = 0;

  // Current windows, used to aim random detections at the edges
  int win_rcs_lo = COORD_MIN;
  int win_rcs_hi = COORD_MAX;
  int win_rng_lo = 0;
  int win_rng_hi = RANGE_MAX;

  radar_keypoint_select #(
    .COORD_WIDTH(COORD_WIDTH),
    .RCS_WIDTH  (RCS_WIDTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .det_i (det_bus),
    .res_o (res_bus),
    .cfg_i (cfg_bus)
  );

  rks_keypoint_checker #(
    .COORD_WIDTH(COORD_WIDTH),
    .RCS_WIDTH  (RCS_WIDTH)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .det_i        (det_bus),
    .res_i        (res_bus),
    .cfg_i        (cfg_bus),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Watchdog: ends the run after a long stretch without any transfer
  always @(posedge clk_i) begin
    if ((det_bus.valid && det_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: stretches of steady, light, heavy or total back-pressure
  initial begin : result_stall
    stall_mode_e mode;
    int          span;
    res_bus.ready = 1'b0;
    forever begin
      mode = stall_mode_e'($urandom_range(STALL_NONE, STALL_FULL));
      span = (mode == STALL_FULL) ? $urandom_range(1, 12) : $urandom_range(4, 60);
      repeat (span) begin
        @(posedge clk_i);
        case (mode)
          STALL_NONE:  res_bus.ready <= 1'b1;
          STALL_LIGHT: res_bus.ready <= ($urandom_range(0, 3) != 0);
          STALL_HEAVY: res_bus.ready <= ($urandom_range(0, 3) == 0);
          default:     res_bus.ready <= 1'b0;
        endcase
      end
    end
  end

  // One detection transfer; opens a new burst, after a random gap, when due
  task automatic det_send(input int x, input int y, input int z, input int rcs,
                          input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        det_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    det_bus.valid         <= 1'b1;
    det_bus.pos_x         <= COORD_WIDTH'(x);
    det_bus.pos_y         <= COORD_WIDTH'(y);
    det_bus.pos_z         <= COORD_WIDTH'(z);
    det_bus.cross_section <= RCS_WIDTH'(rcs);
    det_bus.last_point    <= last;
    @(negedge clk_i);
    while (!det_bus.ready) @(negedge clk_i);
    @(posedge clk_i);
    dets_sent++;
  endtask

  // One register write transfer; valid is left high for a following write
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(negedge clk_i);
    while (!cfg_bus.ready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Wait for the block to go idle, then write the full register set
  task automatic apply_cfg(input int rlo, input int rhi, input int glo, input int ghi,
                           input logic key_rng, input logic pick_min, input bit spare);
    det_bus.valid <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_write(CFG_RCS_LOW,       CFG_DATA_W'(rlo));
    cfg_write(CFG_RCS_HIGH,      CFG_DATA_W'(rhi));
    cfg_write(CFG_RANGE_LOW,     CFG_DATA_W'(glo));
    cfg_write(CFG_RANGE_HIGH,    CFG_DATA_W'(ghi));
    cfg_write(CFG_KEY_IS_RANGE,  CFG_DATA_W'({$urandom(), key_rng}));
    cfg_write(CFG_PICK_SMALLEST, CFG_DATA_W'({$urandom(), pick_min}));
    // unmapped indexes must leave the register set alone
    if (spare)
      for (int s = int'(CFG_PICK_SMALLEST) + 1; s < 2 ** CFG_IDX_W; s++)
        cfg_write(CFG_IDX_W'(s), CFG_DATA_W'($urandom()));
    cfg_bus.valid <= 1'b0;
    win_rcs_lo = rlo;
    win_rcs_hi = rhi;
    win_rng_lo = glo;
    win_rng_hi = ghi;
  endtask

  // Coordinate aimed at the range window edges, or anywhere
  function automatic int rand_axis();
    int v;
    case ($urandom_range(0, 5))
      0:       v = int'($urandom_range(0, 65535)) + COORD_MIN;
      1:       v = win_rng_lo;
      2:       v = win_rng_hi;
      3:       v = 0;
      default: v = $urandom_range(0, (win_rng_hi > win_rng_lo) ? win_rng_hi : win_rng_lo);
    endcase
    if ($urandom_range(0, 1) != 0) v = -v;
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return v;
  endfunction

  // Cross section aimed at the RCS window, its edges, or anywhere
  function automatic int rand_rcs();
    int lo, hi;
    lo = (win_rcs_lo < win_rcs_hi) ? win_rcs_lo : win_rcs_hi;
    hi = (win_rcs_lo < win_rcs_hi) ? win_rcs_hi : win_rcs_lo;
    case ($urandom_range(0, 5))
      0:       return int'($urandom_range(0, 65535)) + COORD_MIN;
      1:       return win_rcs_lo;
      2:       return win_rcs_hi;
      default: return lo + int'($urandom_range(0, hi - lo));
    endcase
  endfunction

  initial begin : stimulus
    int a, b, glo, ghi, shape, clouds, len;
    det_bus.valid         = 1'b0;
    det_bus.pos_x         = '0;
    det_bus.pos_y         = '0;
    det_bus.pos_z         = '0;
    det_bus.cross_section = '0;
    det_bus.last_point    = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = '0;
    cfg_bus.data          = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: largest RCS, corner point qualifies, RCS limits excluded,
    // tie keeps the earlier point, zero range never qualifies
    det_send(COORD_MIN, COORD_MIN, COORD_MAX, 100, 1'b0);
    det_send(COORD_MAX, COORD_MAX, 5, COORD_MAX, 1'b0);
    det_send(1, 0, COORD_MIN, 200, 1'b0);
    det_send(5, 5, 7, 200, 1'b0);
    det_send(100, -100, 3, COORD_MIN, 1'b0);
    det_send(0, 0, 9, 300, 1'b1);
    // nothing qualifies: found low, coordinates zero
    det_send(0, 0, -1, 0, 1'b1);

    // Smallest range, with the lower bound itself excluded and a tie
    apply_cfg(-100, 100, 10, 1000, 1'b1, 1'b1, 1'b1);
    det_send(10, 0, 1, 0, 1'b0);
    det_send(11, 0, 2, 99, 1'b0);
    det_send(0, -12, 3, -99, 1'b0);
    det_send(-11, 0, 4, 5, 1'b0);
    det_send(999, 0, 5, 100, 1'b0);
    det_send(3, 4, 6, 50, 1'b1);

    // Empty RCS window
    apply_cfg(50, 50, 0, RANGE_MAX, 1'b0, 1'b0, 1'b0);
    det_send(20, 20, 1, 50, 1'b0);
    det_send(30, -30, 2, 49, 1'b1);

    // Empty range window
    apply_cfg(COORD_MIN, COORD_MAX, RANGE_MAX, 0, 1'b1, 1'b0, 1'b0);
    det_send(20, 20, 1, 0, 1'b0);
    det_send(-30, 30, 2, 7, 1'b1);

    // Largest range across the full window: the corner wins
    apply_cfg(COORD_MIN, COORD_MAX, 0, RANGE_MAX, 1'b1, 1'b0, 1'b0);
    det_send(COORD_MAX, 0, 1, 1, 1'b0);
    det_send(COORD_MIN, COORD_MIN, 2, -1, 1'b0);
    det_send(1, 1, 3, 2, 1'b1);

    // Random clouds under random settings
    while (dets_sent < DETS_TARGET) begin
      shape = $urandom_range(0, 7);
      if (shape == 0) begin
        apply_cfg(COORD_MIN, COORD_MAX, 0, RANGE_MAX, $urandom_range(0, 1),
                  $urandom_range(0, 1), 1'b0);
      end else begin
        a   = int'($urandom_range(0, 65535)) + COORD_MIN;
        b   = int'($urandom_range(0, 65535)) + COORD_MIN;
        glo = $urandom_range(0, 4000);
        ghi = $urandom_range(glo, RANGE_MAX);
        if (shape == 1)
          // inverted windows: nothing may qualify
          apply_cfg((a > b) ? a : b, (a > b) ? b : a, ghi, glo,
                    $urandom_range(0, 1), $urandom_range(0, 1), 1'b0);
        else
          apply_cfg((a < b) ? a : b, (a < b) ? b : a, glo, ghi,
                    $urandom_range(0, 1), $urandom_range(0, 1), 1'b0);
      end
      clouds = $urandom_range(3, 12);
      repeat (clouds) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
          det_send(rand_axis(), rand_axis(), int'($urandom_range(0, 65535)) + COORD_MIN,
                   rand_rcs(), i == len - 1);
      end
    end

    // Drain: everything owed must arrive, then a short quiet spell
    det_bus.valid <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
